@@ rtl/core/joystick_ema_deadzone_conditioner_unit_defines.svh @@
// Assertion macros shared by the checker of the joystick conditioner.
`ifndef JOYSTICK_EMA_DEADZONE_CONDITIONER_UNIT_DEFINES_SVH
`define JOYSTICK_EMA_DEADZONE_CONDITIONER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JEDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define JEDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/jedc_pkg.sv @@
// Shared widths, reset values and register codes of the joystick conditioner.
package jedc_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int ALPHA_W     = 16;
	localparam int MARGIN_W    = 8;
	localparam int NUM_BTN     = 4;
	localparam int ACC_W       = ALPHA_W + SAMPLE_BITS + 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PAYLOAD_W   = 3 * SAMPLE_BITS + NUM_BTN;
	localparam int TDATA_W     = ((PAYLOAD_W + 7) / 8) * 8;

	localparam logic [SAMPLE_BITS-1:0] CENTER_RESET   = SAMPLE_BITS'(2048);
	localparam logic [SAMPLE_BITS-1:0] DEADZONE_RESET = '0;
	localparam logic [MARGIN_W-1:0]    MARGIN_RESET   = MARGIN_W'(3);
	localparam logic [ALPHA_W-1:0]     ALPHA_RESET    = ALPHA_W'(22938);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_DEADZONE = 3'd2,
		REG_MARGIN   = 3'd3,
		REG_ALPHA    = 3'd4,
		REG_INVERT_X = 3'd5,
		REG_INVERT_Y = 3'd6
	} cfg_reg_t;

endpackage

@@ rtl/core/jedc_ema.sv @@
// One exponential moving average update step for a single sample channel.
module jedc_ema (
	input  jedc_pkg::sample_t               prev,
	input  jedc_pkg::sample_t               raw,
	input  logic [jedc_pkg::ALPHA_W-1:0]    alpha,
	output jedc_pkg::sample_t               filt
);
	import jedc_pkg::*;

	logic signed [SAMPLE_BITS:0] diff;
	logic signed [ACC_W-1:0]     prod;
	logic signed [ACC_W-1:0]     acc;

	// prev + alpha * (raw - prev), all scaled by 2^16; the sum never goes negative.
	always_comb begin
		diff = $signed({1'b0, raw}) - $signed({1'b0, prev});
		prod = ACC_W'($signed({1'b0, alpha})) * ACC_W'(diff);
		acc  = $signed({2'b00, prev, {ALPHA_W{1'b0}}}) + prod;
		filt = acc[ALPHA_W +: SAMPLE_BITS];
	end

endmodule

@@ rtl/core/jedc_axis.sv @@
// Deadzone hysteresis and optional mirroring for one joystick axis.
module jedc_axis (
	input  jedc_pkg::sample_t               filt,
	input  jedc_pkg::sample_t               center,
	input  jedc_pkg::sample_t               deadzone,
	input  logic [jedc_pkg::MARGIN_W-1:0]   margin,
	input  logic                            invert,
	input  logic                            zone,
	output logic                            zone_next,
	output jedc_pkg::sample_t               value
);
	import jedc_pkg::*;

	sample_t                distance;
	logic [SAMPLE_BITS:0]   exit_thresh;
	sample_t                held;

	always_comb begin
		distance    = (filt >= center) ? (filt - center) : (center - filt);
		exit_thresh = {1'b0, deadzone} + (SAMPLE_BITS + 1)'(margin);
		if (zone) begin
			zone_next = ({1'b0, distance} <= exit_thresh);
		end else begin
			zone_next = (distance <= deadzone);
		end
		held  = zone_next ? center : filt;
		value = invert ? ~held : held;
	end

endmodule

@@ rtl/core/joystick_ema_deadzone_conditioner_unit.sv @@
// Top level of the joystick EMA and deadzone conditioner.
//
// Input requests arrive on s_axis: tdata carries raw_x, raw_y, raw_pot and the
// four active-low button levels. Results leave on m_axis with joy_x, joy_y,
// pot_value and the four active-high button states in the same layout.
// Registers are written over the cfg channel, which is always ready; they
// should only change while no request is in flight.
// An accepted request sits in the input register while the moving averages
// and the deadzone decision are computed in one pass, then moves into the
// result register together with the filter and deadzone state. A result is
// offered on m_axis once it sits in the result register, and one request
// per cycle is taken while m_axis_tready is high. When the receiver stalls,
// the result register holds its request and the input register fills, after
// which s_axis_tready falls; nothing is dropped.
// Reset empties both registers, clears the deadzone flags, restores the
// register defaults and rearms seeding, so the first request after reset
// loads the filters directly with its raw samples.
module joystick_ema_deadzone_conditioner_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// raw_x, raw_y, raw_pot, toggle1_level, toggle2_level, push1_level, push2_level
	input  logic [jedc_pkg::TDATA_W-1:0]      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// joy_x, joy_y, pot_value, toggle1_on, toggle2_on, push1_on, push2_on
	output logic [jedc_pkg::TDATA_W-1:0]      m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jedc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jedc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import jedc_pkg::*;

	sample_t               center_x_q, center_y_q, deadzone_q;
	logic [MARGIN_W-1:0]   margin_q;
	logic [ALPHA_W-1:0]    alpha_q;
	logic                  invert_x_q, invert_y_q;

	logic                  valid_s1, valid_s2;
	sample_t               raw_x_s1, raw_y_s1, raw_pot_s1;
	logic [NUM_BTN-1:0]    btn_s1, btn_s2;
	sample_t               filt_x_q, filt_y_q, filt_pot_q;
	logic                  primed_q, zone_x_q, zone_y_q;
	sample_t               joy_x_s2, joy_y_s2, pot_s2;

	logic                  ready_s2, adv_s1;
	sample_t               ema_x, ema_y, ema_pot;
	sample_t               filt_x_next, filt_y_next, filt_pot_next;
	sample_t               axis_x, axis_y;
	logic                  zone_x_next, zone_y_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RESET;
			center_y_q <= CENTER_RESET;
			deadzone_q <= DEADZONE_RESET;
			margin_q   <= MARGIN_RESET;
			alpha_q    <= ALPHA_RESET;
			invert_x_q <= 1'b0;
			invert_y_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_DEADZONE: deadzone_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_MARGIN:   margin_q   <= cfg_data[MARGIN_W-1:0];
				REG_ALPHA:    alpha_q    <= cfg_data[ALPHA_W-1:0];
				REG_INVERT_X: invert_x_q <= cfg_data[0];
				REG_INVERT_Y: invert_y_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || ready_s2;
	assign adv_s1        = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			raw_x_s1   <= s_axis_tdata[0 +: SAMPLE_BITS];
			raw_y_s1   <= s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS];
			raw_pot_s1 <= s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
			btn_s1     <= s_axis_tdata[3*SAMPLE_BITS +: NUM_BTN];
		end
	end

	jedc_ema u_ema_x (
		.prev  (filt_x_q),
		.raw   (raw_x_s1),
		.alpha (alpha_q),
		.filt  (ema_x)
	);

	jedc_ema u_ema_y (
		.prev  (filt_y_q),
		.raw   (raw_y_s1),
		.alpha (alpha_q),
		.filt  (ema_y)
	);

	jedc_ema u_ema_pot (
		.prev  (filt_pot_q),
		.raw   (raw_pot_s1),
		.alpha (alpha_q),
		.filt  (ema_pot)
	);

	assign filt_x_next   = primed_q ? ema_x : raw_x_s1;
	assign filt_y_next   = primed_q ? ema_y : raw_y_s1;
	assign filt_pot_next = primed_q ? ema_pot : raw_pot_s1;

	jedc_axis u_axis_x (
		.filt      (filt_x_next),
		.center    (center_x_q),
		.deadzone  (deadzone_q),
		.margin    (margin_q),
		.invert    (invert_x_q),
		.zone      (zone_x_q),
		.zone_next (zone_x_next),
		.value     (axis_x)
	);

	jedc_axis u_axis_y (
		.filt      (filt_y_next),
		.center    (center_y_q),
		.deadzone  (deadzone_q),
		.margin    (margin_q),
		.invert    (invert_y_q),
		.zone      (zone_y_q),
		.zone_next (zone_y_next),
		.value     (axis_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			primed_q <= 1'b0;
			zone_x_q <= 1'b0;
			zone_y_q <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				primed_q <= 1'b1;
				zone_x_q <= zone_x_next;
				zone_y_q <= zone_y_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			filt_x_q   <= filt_x_next;
			filt_y_q   <= filt_y_next;
			filt_pot_q <= filt_pot_next;
			joy_x_s2   <= axis_x;
			joy_y_s2   <= axis_y;
			pot_s2     <= filt_pot_next;
			btn_s2     <= ~btn_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = TDATA_W'({btn_s2, pot_s2, joy_y_s2, joy_x_s2});

endmodule

@@ rtl/core/jedc_checker.sv @@
// Port-level checker of the joystick conditioner and its bind statement.
`include "joystick_ema_deadzone_conditioner_unit_defines.svh"

module jedc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tready,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [jedc_pkg::TDATA_W-1:0]      m_axis_tdata,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready
);

	// A stalled result keeps its request and its data.
	`JEDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	// Backpressure on the input only appears with a result waiting.
	`JEDC_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with no result pending")
	// A ready receiver always lets a new request in.
	`JEDC_ASSERT_NOW(a_ready_pass, m_axis_tready, s_axis_tready, "input stalled while output ready")
	// Register writes are never held off.
	`JEDC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write refused")

endmodule

bind joystick_ema_deadzone_conditioner_unit jedc_checker u_jedc_checker (.*);
